// ===== rtl/tqrb_pkg.sv =====
// ----------------------------------------------------------------------------
// tqrb_pkg
// Shared types and constants for the transmit queue with retry backoff.
// ----------------------------------------------------------------------------
package tqrb_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 12;
	localparam int DELAY_W     = 16;

	// event codes
	localparam logic [1:0] OP_ENQUEUE = 2'd0;
	localparam logic [1:0] OP_ACK     = 2'd1;
	localparam logic [1:0] OP_FAIL    = 2'd2;
	localparam logic [1:0] OP_TIMER   = 2'd3;

	// link outcome codes, anything else counts as refused
	localparam logic [1:0] LINK_ACCEPT = 2'd0;
	localparam logic [1:0] LINK_BUSY   = 2'd1;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_GIVE_UP_LIMIT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_BACKOFF  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_DOUBLINGS = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BUSY_DELAY    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_REFUSED_DELAY = 3'd4;

	// register reset values
	localparam logic [3:0]  RST_GIVE_UP_LIMIT = 4'd10;
	localparam logic [11:0] RST_BASE_BACKOFF  = 12'd250;
	localparam logic [2:0]  RST_MAX_DOUBLINGS = 3'd4;
	localparam logic [11:0] RST_BUSY_DELAY    = 12'd120;
	localparam logic [11:0] RST_REFUSED_DELAY = 12'd160;

	localparam logic [2:0] DOUBLING_CAP = 3'd4;

	typedef struct packed {
		logic capture;
		logic update;
		logic send;
	} cmd_t;

	typedef struct packed {
		logic skip_send;
	} status_t;

endpackage

// ===== rtl/tx_queue_retry_backoff.sv =====
// ----------------------------------------------------------------------------
// tx_queue_retry_backoff
// Transmit request queue with one send in flight and exponential retry backoff.
// ----------------------------------------------------------------------------
// sequence: a failure event or a dropped enqueue goes from the update step
//   straight to the response; every other event passes the update and send steps
// handshake: the next request is taken in the cycle the response is taken;
//   no request is taken during the update and send steps
// reset: queue empty, nothing in flight, failure count zero, registers to
//   defaults; queue entries are not cleared and are never read before written
module tx_queue_retry_backoff #(
	parameter int QUEUE_DEPTH = 6
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [tqrb_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [tqrb_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic [1:0]                           opcode,
	input  logic signed [31:0]                   request_code,
	input  logic signed [31:0]                   first_word,
	input  logic signed [31:0]                   second_word,
	input  logic                                 has_text,
	input  logic [1:0]                           link_status,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output logic                                 tx_valid,
	output logic signed [31:0]                   tx_request,
	output logic signed [31:0]                   tx_first,
	output logic signed [31:0]                   tx_second,
	output logic                                 tx_text,
	output logic [tqrb_pkg::DELAY_W-1:0]         retry_delay_ms,
	output logic                                 dropped_full,
	output logic                                 abandoned,
	output logic [2:0]                           queue_count
);

	tqrb_pkg::cmd_t    cmd;
	tqrb_pkg::status_t status;

	tqrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.cmd       (cmd)
	);

	tqrb_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.opcode         (opcode),
		.request_code   (request_code),
		.first_word     (first_word),
		.second_word    (second_word),
		.has_text       (has_text),
		.link_status    (link_status),
		.tx_valid       (tx_valid),
		.tx_request     (tx_request),
		.tx_first       (tx_first),
		.tx_second      (tx_second),
		.tx_text        (tx_text),
		.retry_delay_ms (retry_delay_ms),
		.dropped_full   (dropped_full),
		.abandoned      (abandoned),
		.queue_count    (queue_count)
	);

endmodule

// ===== rtl/tqrb_ctrl.sv =====
// ----------------------------------------------------------------------------
// tqrb_ctrl
// Sequencer: takes a request, steps the datapath through update and, unless
// the update skips it, send, then holds the response until it is taken.
// ----------------------------------------------------------------------------
module tqrb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  tqrb_pkg::status_t status,
	output tqrb_pkg::cmd_t    cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_UPDATE = 2'd1;
	localparam logic [1:0] S_SEND   = 2'd2;
	localparam logic [1:0] S_OUT    = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       accept;

	assign req_stall = !((state_q == S_IDLE) || ((state_q == S_OUT) && !rsp_stall));
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = (state_q == S_OUT);

	assign cmd.capture = accept;
	assign cmd.update  = (state_q == S_UPDATE);
	assign cmd.send    = (state_q == S_SEND);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nxt = S_UPDATE;
				end
			end
			S_UPDATE: begin
				state_nxt = status.skip_send ? S_OUT : S_SEND;
			end
			S_SEND: begin
				state_nxt = S_OUT;
			end
			S_OUT: begin
				if (!rsp_stall) begin
					state_nxt = accept ? S_UPDATE : S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	a_accept_starts_update: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_UPDATE)
		else $error("accepted transfer did not start an update");

	a_rsp_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> ($past(state_q) == S_UPDATE || $past(state_q) == S_SEND))
		else $error("response raised without update or send");

endmodule

// ===== rtl/tqrb_dpath.sv =====
// ----------------------------------------------------------------------------
// tqrb_dpath
// Ring queue storage, head and count pointers, failure counter, backoff
// calculation, configuration registers and the response register.
// ----------------------------------------------------------------------------
module tqrb_dpath #(
	parameter int QUEUE_DEPTH = 6
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  tqrb_pkg::cmd_t                             cmd,
	output tqrb_pkg::status_t                          status,
	input  logic                                       cfg_we,
	input  logic [tqrb_pkg::CFG_INDEX_W-1:0]           cfg_index,
	input  logic [tqrb_pkg::CFG_DATA_W-1:0]            cfg_wdata,
	input  logic [1:0]                                 opcode,
	input  logic signed [31:0]                         request_code,
	input  logic signed [31:0]                         first_word,
	input  logic signed [31:0]                         second_word,
	input  logic                                       has_text,
	input  logic [1:0]                                 link_status,
	output logic                                       tx_valid,
	output logic signed [31:0]                         tx_request,
	output logic signed [31:0]                         tx_first,
	output logic signed [31:0]                         tx_second,
	output logic                                       tx_text,
	output logic [tqrb_pkg::DELAY_W-1:0]               retry_delay_ms,
	output logic                                       dropped_full,
	output logic                                       abandoned,
	output logic [2:0]                                 queue_count
);

	localparam int IDXW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
	localparam int SUMW = $clog2(2 * QUEUE_DEPTH);

	// captured request
	logic [1:0]         op_q;
	logic signed [31:0] code_q;
	logic signed [31:0] first_q;
	logic signed [31:0] second_q;
	logic               text_q;
	logic [1:0]         link_q;

	// configuration
	logic [3:0]  limit_q;
	logic [11:0] base_q;
	logic [2:0]  maxd_q;
	logic [11:0] busy_q;
	logic [11:0] refused_q;

	// queue storage
	logic signed [31:0] code_mem_q   [QUEUE_DEPTH];
	logic signed [31:0] first_mem_q  [QUEUE_DEPTH];
	logic signed [31:0] second_mem_q [QUEUE_DEPTH];
	logic               text_mem_q   [QUEUE_DEPTH];

	logic [IDXW-1:0] head_q;
	logic [CNTW-1:0] count_q;
	logic            in_flight_q;
	logic [3:0]      fail_q;

	logic                      full;
	logic                      empty;
	logic [SUMW-1:0]           tail_sum;
	logic [SUMW-1:0]           tail_wrap;
	logic [IDXW-1:0]           tail_idx;
	logic [IDXW-1:0]           head_nxt;
	logic [CNTW-1:0]           count_nxt;
	logic [4:0]                fail_inc;
	logic                      give_up;
	logic [3:0]                fail_new;
	logic [2:0]                dbl_cfg;
	logic [2:0]                dbl;
	logic [tqrb_pkg::DELAY_W-1:0] backoff;
	logic                      do_enq;
	logic                      do_pop;
	logic                      send_try;
	logic                      send_ok;

	always_comb begin
		full      = (count_q == CNTW'(QUEUE_DEPTH));
		empty     = (count_q == '0);
		tail_sum  = SUMW'(head_q) + SUMW'(count_q);
		tail_wrap = (tail_sum >= SUMW'(QUEUE_DEPTH)) ? tail_sum - SUMW'(QUEUE_DEPTH) : tail_sum;
		tail_idx  = IDXW'(tail_wrap);
		head_nxt  = (head_q == IDXW'(QUEUE_DEPTH - 1)) ? '0 : head_q + IDXW'(1);

		fail_inc = {1'b0, fail_q} + 5'd1;
		give_up  = (fail_inc > {1'b0, limit_q});
		fail_new = give_up ? 4'd0 : fail_inc[3:0];
		dbl_cfg  = (fail_new > {1'b0, maxd_q}) ? maxd_q : fail_new[2:0];
		dbl      = (dbl_cfg > tqrb_pkg::DOUBLING_CAP) ? tqrb_pkg::DOUBLING_CAP : dbl_cfg;
		backoff  = {4'd0, base_q} << dbl;

		do_enq = (op_q == tqrb_pkg::OP_ENQUEUE) && !full;
		do_pop = !empty && ((op_q == tqrb_pkg::OP_ACK) ||
			((op_q == tqrb_pkg::OP_FAIL) && give_up));

		count_nxt = count_q;
		if (do_enq) begin
			count_nxt = count_q + CNTW'(1);
		end
		if (do_pop) begin
			count_nxt = count_q - CNTW'(1);
		end

		// evaluated in the send step, after the update has landed
		send_try = !in_flight_q && !empty;
		send_ok  = send_try && (link_q == tqrb_pkg::LINK_ACCEPT);

		status.skip_send = (op_q == tqrb_pkg::OP_FAIL) ||
			((op_q == tqrb_pkg::OP_ENQUEUE) && full);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= opcode;
			code_q   <= request_code;
			first_q  <= first_word;
			second_q <= second_word;
			text_q   <= has_text;
			link_q   <= link_status;
		end
		if (cmd.update && do_enq) begin
			code_mem_q[tail_idx]   <= code_q;
			first_mem_q[tail_idx]  <= first_q;
			second_mem_q[tail_idx] <= second_q;
			text_mem_q[tail_idx]   <= text_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= tqrb_pkg::RST_GIVE_UP_LIMIT;
			base_q    <= tqrb_pkg::RST_BASE_BACKOFF;
			maxd_q    <= tqrb_pkg::RST_MAX_DOUBLINGS;
			busy_q    <= tqrb_pkg::RST_BUSY_DELAY;
			refused_q <= tqrb_pkg::RST_REFUSED_DELAY;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tqrb_pkg::REG_GIVE_UP_LIMIT: limit_q   <= cfg_wdata[3:0];
				tqrb_pkg::REG_BASE_BACKOFF:  base_q    <= cfg_wdata;
				tqrb_pkg::REG_MAX_DOUBLINGS: maxd_q    <= cfg_wdata[2:0];
				tqrb_pkg::REG_BUSY_DELAY:    busy_q    <= cfg_wdata;
				tqrb_pkg::REG_REFUSED_DELAY: refused_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			in_flight_q <= 1'b0;
			fail_q      <= 4'd0;
		end else if (cmd.update) begin
			if ((op_q == tqrb_pkg::OP_ACK) || (op_q == tqrb_pkg::OP_FAIL)) begin
				in_flight_q <= 1'b0;
			end
			if (do_pop) begin
				head_q <= head_nxt;
			end
			count_q <= count_nxt;
			if (op_q == tqrb_pkg::OP_FAIL) begin
				fail_q <= fail_new;
			end else if (do_pop) begin
				fail_q <= 4'd0;
			end
		end else if (cmd.send && send_ok) begin
			in_flight_q <= 1'b1;
		end
	end

	// response register, written in the update and send steps, held until the next update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_valid       <= 1'b0;
			tx_request     <= '0;
			tx_first       <= '0;
			tx_second      <= '0;
			tx_text        <= 1'b0;
			retry_delay_ms <= '0;
			dropped_full   <= 1'b0;
			abandoned      <= 1'b0;
			queue_count    <= '0;
		end else if (cmd.update) begin
			tx_valid       <= 1'b0;
			tx_request     <= '0;
			tx_first       <= '0;
			tx_second      <= '0;
			tx_text        <= 1'b0;
			retry_delay_ms <= (op_q == tqrb_pkg::OP_FAIL) ? backoff : '0;
			dropped_full   <= (op_q == tqrb_pkg::OP_ENQUEUE) && full;
			abandoned      <= (op_q == tqrb_pkg::OP_FAIL) && give_up && !empty;
			queue_count    <= 3'(count_nxt);
		end else if (cmd.send && send_try) begin
			if (link_q == tqrb_pkg::LINK_BUSY) begin
				retry_delay_ms <= tqrb_pkg::DELAY_W'(busy_q);
			end else if (link_q != tqrb_pkg::LINK_ACCEPT) begin
				retry_delay_ms <= tqrb_pkg::DELAY_W'(refused_q);
			end else begin
				tx_valid   <= 1'b1;
				tx_request <= code_mem_q[head_q];
				tx_first   <= first_mem_q[head_q];
				tx_second  <= second_mem_q[head_q];
				tx_text    <= text_mem_q[head_q];
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_send_sets_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.send && send_ok) |=> (in_flight_q && tx_valid))
		else $error("transfer to link without in-flight mark");

	a_abandon_clears_fail: assert property (@(posedge clk) disable iff (!arst_n)
		abandoned |-> (fail_q == 4'd0))
		else $error("abandoned head left a failure count");

endmodule

// ===== tb/tb_tx_queue_retry_backoff.sv =====
// ----------------------------------------------------------------------------
// tb_tx_queue_retry_backoff
// Self-checking bench for the transmit queue with retry backoff. A tracker
// class mirrors the ring queue, the in-flight flag and the failure count and
// predicts one response per accepted event. Directed events cover the field
// extremes, every event code, the full queue, abandon and the link outcomes.
// Random sequences then run under several register settings while both
// handshake sides idle in bursts.
// ----------------------------------------------------------------------------
module tb_tx_queue_retry_backoff;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUEUE_DEPTH  = 6;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 10;

	// link outcomes with no name in the package
	localparam logic [1:0] LINK_REFUSED = 2'd2;
	localparam logic [1:0] LINK_UNKNOWN = 2'd3;

	typedef struct packed {
		logic        tx_valid;
		logic [31:0] tx_request;
		logic [31:0] tx_first;
		logic [31:0] tx_second;
		logic        tx_text;
		logic [15:0] retry_delay;
		logic        dropped_full;
		logic        abandoned;
		logic [2:0]  queue_count;
	} outcome_t;

	class tx_backoff_tracker;
		logic [31:0] code_mem [QUEUE_DEPTH];
		logic [31:0] first_mem [QUEUE_DEPTH];
		logic [31:0] second_mem [QUEUE_DEPTH];
		logic        text_mem [QUEUE_DEPTH];
		int unsigned head;
		int unsigned count;
		int unsigned fail_count;
		bit          in_flight;
		logic [3:0]  give_up;
		logic [11:0] base_ms;
		logic [2:0]  max_dbl;
		logic [11:0] busy_ms;
		logic [11:0] refused_ms;
		outcome_t    predicted[$];
		int          mismatches;

		function new();
			head = 0;
			count = 0;
			fail_count = 0;
			in_flight = 1'b0;
			give_up = tqrb_pkg::RST_GIVE_UP_LIMIT;
			base_ms = tqrb_pkg::RST_BASE_BACKOFF;
			max_dbl = tqrb_pkg::RST_MAX_DOUBLINGS;
			busy_ms = tqrb_pkg::RST_BUSY_DELAY;
			refused_ms = tqrb_pkg::RST_REFUSED_DELAY;
			mismatches = 0;
		endfunction

		function void write_reg(logic [tqrb_pkg::CFG_INDEX_W-1:0] idx,
				logic [tqrb_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				tqrb_pkg::REG_GIVE_UP_LIMIT: give_up = data[3:0];
				tqrb_pkg::REG_BASE_BACKOFF:  base_ms = data;
				tqrb_pkg::REG_MAX_DOUBLINGS: max_dbl = data[2:0];
				tqrb_pkg::REG_BUSY_DELAY:    busy_ms = data;
				tqrb_pkg::REG_REFUSED_DELAY: refused_ms = data;
				default: ;
			endcase
		endfunction

		function void drop_head();
			if (count == 0)
				return;
			head = (head + 1) % QUEUE_DEPTH;
			count--;
			fail_count = 0;
		endfunction

		function void try_send(logic [1:0] status, inout outcome_t o);
			if (in_flight || count == 0)
				return;
			if (status == tqrb_pkg::LINK_BUSY) begin
				o.retry_delay = {4'd0, busy_ms};
				return;
			end
			if (status != tqrb_pkg::LINK_ACCEPT) begin
				o.retry_delay = {4'd0, refused_ms};
				return;
			end
			o.tx_valid = 1'b1;
			o.tx_request = code_mem[head];
			o.tx_first = first_mem[head];
			o.tx_second = second_mem[head];
			o.tx_text = text_mem[head];
			in_flight = 1'b1;
		endfunction

		function void note_request(logic [1:0] op, logic [31:0] code, logic [31:0] first,
				logic [31:0] second, logic text, logic [1:0] status);
			outcome_t    o;
			int unsigned slot;
			int unsigned nxt;
			int unsigned dbl;
			o = '0;
			case (op)
				tqrb_pkg::OP_ENQUEUE: begin
					if (count >= QUEUE_DEPTH) begin
						o.dropped_full = 1'b1;
					end else begin
						slot = (head + count) % QUEUE_DEPTH;
						code_mem[slot] = code;
						first_mem[slot] = first;
						second_mem[slot] = second;
						text_mem[slot] = text;
						count++;
						try_send(status, o);
					end
				end
				tqrb_pkg::OP_ACK: begin
					in_flight = 1'b0;
					drop_head();
					try_send(status, o);
				end
				tqrb_pkg::OP_FAIL: begin
					nxt = fail_count + 1;
					in_flight = 1'b0;
					if (nxt > give_up) begin
						if (count != 0)
							o.abandoned = 1'b1;
						drop_head();
						fail_count = 0;
					end else begin
						fail_count = nxt;
					end
					dbl = fail_count;
					if (dbl > max_dbl)
						dbl = 32'(max_dbl);
					if (dbl > tqrb_pkg::DOUBLING_CAP)
						dbl = 32'(tqrb_pkg::DOUBLING_CAP);
					o.retry_delay = {4'd0, base_ms} << dbl;
				end
				tqrb_pkg::OP_TIMER: try_send(status, o);
				default: ;
			endcase
			o.queue_count = count[2:0];
			predicted.push_back(o);
		endfunction

		task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
			$display("[%0t] mismatch on %s: got %h, expected %h", $time, field, got, want);
			mismatches++;
		endtask

		task check_response(outcome_t got);
			outcome_t want;
			if (predicted.size() == 0) begin
				report_mismatch("response with nothing pending", 32'd0, 32'd0);
				return;
			end
			want = predicted.pop_front();
			if (got.tx_valid !== want.tx_valid)
				report_mismatch("tx_valid", 32'(got.tx_valid), 32'(want.tx_valid));
			if (got.tx_request !== want.tx_request)
				report_mismatch("tx_request", got.tx_request, want.tx_request);
			if (got.tx_first !== want.tx_first)
				report_mismatch("tx_first", got.tx_first, want.tx_first);
			if (got.tx_second !== want.tx_second)
				report_mismatch("tx_second", got.tx_second, want.tx_second);
			if (got.tx_text !== want.tx_text)
				report_mismatch("tx_text", 32'(got.tx_text), 32'(want.tx_text));
			if (got.retry_delay !== want.retry_delay)
				report_mismatch("retry_delay_ms", 32'(got.retry_delay),
					32'(want.retry_delay));
			if (got.dropped_full !== want.dropped_full)
				report_mismatch("dropped_full", 32'(got.dropped_full),
					32'(want.dropped_full));
			if (got.abandoned !== want.abandoned)
				report_mismatch("abandoned", 32'(got.abandoned), 32'(want.abandoned));
			if (got.queue_count !== want.queue_count)
				report_mismatch("queue_count", 32'(got.queue_count),
					32'(want.queue_count));
		endtask

		function int pending();
			return predicted.size();
		endfunction
	endclass

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [tqrb_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [tqrb_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                             req_valid = 1'b0;
	logic                             req_stall;
	logic [1:0]                       opcode = tqrb_pkg::OP_TIMER;
	logic signed [31:0]               request_code = '0;
	logic signed [31:0]               first_word = '0;
	logic signed [31:0]               second_word = '0;
	logic                             has_text = 1'b0;
	logic [1:0]                       link_status = tqrb_pkg::LINK_ACCEPT;
	logic                             rsp_valid;
	logic                             rsp_stall = 1'b0;
	logic                             tx_valid;
	logic signed [31:0]               tx_request;
	logic signed [31:0]               tx_first;
	logic signed [31:0]               tx_second;
	logic                             tx_text;
	logic [tqrb_pkg::DELAY_W-1:0]     retry_delay_ms;
	logic                             dropped_full;
	logic                             abandoned;
	logic [2:0]                       queue_count;

	tx_backoff_tracker sb;
	outcome_t          seen;
	int                burst_left = 0;
	int                stall_tick = 0;
	int                stall_mode = 0;
	int                cycle_count = 0;

	tx_queue_retry_backoff #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.opcode(opcode),
		.request_code(request_code),
		.first_word(first_word),
		.second_word(second_word),
		.has_text(has_text),
		.link_status(link_status),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.tx_valid(tx_valid),
		.tx_request(tx_request),
		.tx_first(tx_first),
		.tx_second(tx_second),
		.tx_text(tx_text),
		.retry_delay_ms(retry_delay_ms),
		.dropped_full(dropped_full),
		.abandoned(abandoned),
		.queue_count(queue_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_tx_queue_retry_backoff: FAIL");
			$finish;
		end
	end

	// response side: check each transfer, stall in one of four modes picked at random
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			seen.tx_valid = tx_valid;
			seen.tx_request = tx_request;
			seen.tx_first = tx_first;
			seen.tx_second = tx_second;
			seen.tx_text = tx_text;
			seen.retry_delay = retry_delay_ms;
			seen.dropped_full = dropped_full;
			seen.abandoned = abandoned;
			seen.queue_count = queue_count;
			sb.check_response(seen);
		end
		stall_tick++;
		if (stall_tick % 48 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= ($urandom_range(0, 3) == 0);
			2: rsp_stall <= ($urandom_range(0, 3) != 0);
			default: rsp_stall <= ((stall_tick / 3) % 2 == 1);
		endcase
	end

	task automatic push_request(logic [1:0] op, logic [31:0] code, logic [31:0] first,
			logic [31:0] second, logic text, logic [1:0] status);
		int gap;
		req_valid <= 1'b1;
		opcode <= op;
		request_code <= code;
		first_word <= first;
		second_word <= second;
		has_text <= text;
		link_status <= status;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(op, code, first, second, text, status);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) :
				$urandom_range(0, 12);
		end
	endtask

	// wait for the queue of predictions to empty, then allow for the pipeline
	task automatic settle();
		req_valid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_config(logic [11:0] give_up, logic [11:0] base,
			logic [11:0] max_dbl, logic [11:0] busy, logic [11:0] refused);
		logic [tqrb_pkg::CFG_INDEX_W-1:0] idx [5];
		logic [11:0]                      val [5];
		idx = '{tqrb_pkg::REG_GIVE_UP_LIMIT, tqrb_pkg::REG_BASE_BACKOFF,
			tqrb_pkg::REG_MAX_DOUBLINGS, tqrb_pkg::REG_BUSY_DELAY,
			tqrb_pkg::REG_REFUSED_DELAY};
		val = '{give_up, base, max_dbl, busy, refused};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_wdata <= val[i];
			@(posedge clk);
			sb.write_reg(idx[i], val[i]);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 11))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [1:0] pick_status();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return tqrb_pkg::LINK_ACCEPT;
		if (r < 8)
			return tqrb_pkg::LINK_BUSY;
		if (r < 9)
			return LINK_REFUSED;
		return LINK_UNKNOWN;
	endfunction

	task automatic random_items(int n);
		int         done;
		int         len;
		logic [1:0] op;
		done = 0;
		while (done < n) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					op = 2'($urandom_range(0, 3));
					push_request(op, pick_word(), pick_word(), pick_word(),
						1'($urandom_range(0, 1)), pick_status());
					done++;
				end
				4, 5: begin
					// enough enqueues to hit the full queue now and then
					len = $urandom_range(3, 8);
					repeat (len) push_request(tqrb_pkg::OP_ENQUEUE, pick_word(), pick_word(),
						pick_word(), 1'($urandom_range(0, 1)), pick_status());
					done += len;
				end
				6, 7: begin
					// run of failures to reach the give-up limit
					len = $urandom_range(1, 17);
					repeat (len) push_request(tqrb_pkg::OP_FAIL, pick_word(), pick_word(),
						pick_word(), 1'($urandom_range(0, 1)), pick_status());
					done += len;
				end
				default: begin
					push_request(tqrb_pkg::OP_TIMER, pick_word(), pick_word(), pick_word(),
						1'($urandom_range(0, 1)), pick_status());
					push_request(tqrb_pkg::OP_ACK, pick_word(), pick_word(), pick_word(),
						1'($urandom_range(0, 1)), pick_status());
					done += 2;
				end
			endcase
		end
	endtask

	initial begin
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults, empty queue first
		push_request(tqrb_pkg::OP_TIMER, 32'd0, 32'd0, 32'd0, 1'b0, tqrb_pkg::LINK_ACCEPT);
		push_request(tqrb_pkg::OP_ACK, 32'd0, 32'd0, 32'd0, 1'b0, tqrb_pkg::LINK_ACCEPT);
		push_request(tqrb_pkg::OP_FAIL, 32'd0, 32'd0, 32'd0, 1'b0, tqrb_pkg::LINK_ACCEPT);
		push_request(tqrb_pkg::OP_ENQUEUE, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
			1'b1, tqrb_pkg::LINK_BUSY);
		push_request(tqrb_pkg::OP_TIMER, 32'd0, 32'd0, 32'd0, 1'b0, LINK_REFUSED);
		push_request(tqrb_pkg::OP_TIMER, 32'd0, 32'd0, 32'd0, 1'b0, LINK_UNKNOWN);
		push_request(tqrb_pkg::OP_TIMER, 32'd0, 32'd0, 32'd0, 1'b0, tqrb_pkg::LINK_ACCEPT);
		push_request(tqrb_pkg::OP_ENQUEUE, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
			1'b0, tqrb_pkg::LINK_ACCEPT);
		push_request(tqrb_pkg::OP_ENQUEUE, 32'hffff_ffff, 32'h0000_0000, 32'h7fff_ffff,
			1'b1, tqrb_pkg::LINK_ACCEPT);
		push_request(tqrb_pkg::OP_ENQUEUE, 32'h0000_0000, 32'hffff_ffff, 32'h8000_0000,
			1'b0, tqrb_pkg::LINK_ACCEPT);
		push_request(tqrb_pkg::OP_ENQUEUE, 32'h5555_aaaa, 32'haaaa_5555, 32'h0f0f_f0f0,
			1'b1, tqrb_pkg::LINK_ACCEPT);
		push_request(tqrb_pkg::OP_ENQUEUE, 32'h1234_5678, 32'h9abc_def0, 32'hdead_beef,
			1'b0, tqrb_pkg::LINK_ACCEPT);
		// queue holds six entries now, so this one is dropped
		push_request(tqrb_pkg::OP_ENQUEUE, 32'h0bad_0bad, 32'h0bad_0bad, 32'h0bad_0bad,
			1'b1, tqrb_pkg::LINK_ACCEPT);
		push_request(tqrb_pkg::OP_FAIL, 32'd0, 32'd0, 32'd0, 1'b0, tqrb_pkg::LINK_ACCEPT);
		push_request(tqrb_pkg::OP_ACK, 32'd0, 32'd0, 32'd0, 1'b0, tqrb_pkg::LINK_ACCEPT);

		// give up at once, largest delays, zero busy delay, doubling cap above four
		settle();
		apply_config(12'd0, 12'd4095, 12'd7, 12'd0, 12'd4095);
		push_request(tqrb_pkg::OP_FAIL, 32'd0, 32'd0, 32'd0, 1'b0, tqrb_pkg::LINK_ACCEPT);
		push_request(tqrb_pkg::OP_FAIL, 32'd0, 32'd0, 32'd0, 1'b0, tqrb_pkg::LINK_ACCEPT);
		push_request(tqrb_pkg::OP_TIMER, 32'd0, 32'd0, 32'd0, 1'b0, tqrb_pkg::LINK_BUSY);
		push_request(tqrb_pkg::OP_TIMER, 32'd0, 32'd0, 32'd0, 1'b0, LINK_REFUSED);
		push_request(tqrb_pkg::OP_FAIL, 32'd0, 32'd0, 32'd0, 1'b0, tqrb_pkg::LINK_ACCEPT);
		push_request(tqrb_pkg::OP_FAIL, 32'd0, 32'd0, 32'd0, 1'b0, tqrb_pkg::LINK_ACCEPT);
		push_request(tqrb_pkg::OP_FAIL, 32'd0, 32'd0, 32'd0, 1'b0, tqrb_pkg::LINK_ACCEPT);
		push_request(tqrb_pkg::OP_FAIL, 32'd0, 32'd0, 32'd0, 1'b0, tqrb_pkg::LINK_ACCEPT);

		for (int phase = 0; phase < 6; phase++) begin
			settle();
			case (phase)
				0: apply_config(12'd10, 12'd250, 12'd4, 12'd120, 12'd160);
				1: apply_config(12'd15, 12'd4095, 12'd4, 12'd4095, 12'd0);
				2: apply_config(12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
				3: apply_config(12'd3, 12'd1, 12'd2, 12'd5, 12'd7);
				// upper bits beyond each register width are written too
				4: apply_config(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
					12'($urandom));
				default: apply_config(12'($urandom_range(1, 4)), 12'($urandom),
					12'($urandom_range(0, 4)), 12'($urandom), 12'($urandom));
			endcase
			random_items(115);
		end

		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("tb_tx_queue_retry_backoff: PASS");
		else
			$display("tb_tx_queue_retry_backoff: FAIL");
		$finish;
	end

endmodule

// ===== tx_queue_retry_backoff.f =====
rtl/tqrb_pkg.sv
rtl/tqrb_ctrl.sv
rtl/tqrb_dpath.sv
rtl/tx_queue_retry_backoff.sv
tb/tb_tx_queue_retry_backoff.sv
